// ===== design/afu_pkg.sv =====
// ----------------------------------------------------------------------------
// afu_pkg
// Shared types, mode codes and the sigmoid breakpoint table of the
// activation function unit.
// ----------------------------------------------------------------------------
package afu_pkg;

    localparam int DATA_W = 16;   // sample width, signed Q4.12
    localparam int FRAC_W = 12;   // fractional bits
    localparam int MODE_W = 4;
    localparam int IDX_W  = 6;    // log2 of the segment count
    localparam int REM_W  = DATA_W - IDX_W;
    localparam int LUT_N  = 65;   // segment count plus one
    localparam int LADR_W = IDX_W + 1;
    localparam int LUT_W  = FRAC_W;
    localparam int ACC_W  = LUT_W + REM_W + 1;
    localparam int OP_W   = FRAC_W + 1;
    localparam int PROD_W = 2 * OP_W;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [MODE_W-1:0]        t_mode;

    localparam t_mode MODE_LINEAR    = 4'd0;
    localparam t_mode MODE_LINEAR_D  = 4'd1;
    localparam t_mode MODE_STEP      = 4'd2;
    localparam t_mode MODE_STEP_D    = 4'd3;
    localparam t_mode MODE_SIGMOID   = 4'd4;
    localparam t_mode MODE_SIGMOID_D = 4'd5;
    localparam t_mode MODE_RELU      = 4'd6;
    localparam t_mode MODE_RELU_D    = 4'd7;
    localparam t_mode MODE_TANH      = 4'd8;
    localparam t_mode MODE_TANH_D    = 4'd9;

    localparam t_data ONE_FX   = t_data'(1 << FRAC_W);
    localparam t_data DATA_MAX = t_data'((1 << (DATA_W - 1)) - 1);
    localparam t_data DATA_MIN = t_data'(-(1 << (DATA_W - 1)));

    // Mode and the result of the functions that need no table travel with
    // every sample.
    typedef struct packed {
        t_mode mode;
        t_data y_simple;
    } t_tag;

    typedef struct packed {
        t_tag  tag;
        t_data arg;
    } t_arg_st;

    typedef struct packed {
        t_tag             tag;
        logic [LUT_W-1:0] sig;
    } t_sig_st;

    // Sigmoid at x = k/4 - 8 for k = 0..64, in Q0.12.
    localparam logic [LUT_W-1:0] SIG_LUT [LUT_N] = '{
        12'd1,    12'd2,    12'd2,    12'd3,    12'd4,    12'd5,    12'd6,    12'd8,
        12'd10,   12'd13,   12'd17,   12'd21,   12'd27,   12'd35,   12'd45,   12'd58,
        12'd74,   12'd94,   12'd120,  12'd153,  12'd194,  12'd246,  12'd311,  12'd391,
        12'd488,  12'd606,  12'd747,  12'd912,  12'd1102, 12'd1314, 12'd1546, 12'd1793,
        12'd2048, 12'd2303, 12'd2550, 12'd2782, 12'd2994, 12'd3184, 12'd3349, 12'd3490,
        12'd3608, 12'd3705, 12'd3785, 12'd3850, 12'd3902, 12'd3943, 12'd3976, 12'd4002,
        12'd4022, 12'd4038, 12'd4051, 12'd4061, 12'd4069, 12'd4075, 12'd4079, 12'd4083,
        12'd4086, 12'd4088, 12'd4090, 12'd4091, 12'd4092, 12'd4093, 12'd4094, 12'd4094,
        12'd4095
    };

endpackage

// ===== design/afu_x_if.sv =====
// ----------------------------------------------------------------------------
// afu_x_if
// Input sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface afu_x_if;
    logic           valid;
    logic           ready;
    afu_pkg::t_data x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

// ===== design/afu_y_if.sv =====
// ----------------------------------------------------------------------------
// afu_y_if
// Result sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface afu_y_if;
    logic           valid;
    logic           ready;
    afu_pkg::t_data y_value;

    modport source (output valid, output y_value, input ready);
    modport sink   (input valid, input y_value, output ready);
endinterface

// ===== design/afu_sigmoid.sv =====
// ----------------------------------------------------------------------------
// afu_sigmoid
// Two pipeline stages: breakpoint lookup, then linear interpolation.
// ----------------------------------------------------------------------------
module afu_sigmoid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  afu_pkg::t_arg_st  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output afu_pkg::t_sig_st  o_data
);

    logic                          r_v2;
    afu_pkg::t_tag                 r_tag2;
    logic [afu_pkg::LUT_W-1:0]     r_base2;
    logic [afu_pkg::LUT_W-1:0]     r_diff2;
    logic [afu_pkg::REM_W-1:0]     r_rem2;
    logic                          r_v3;
    afu_pkg::t_sig_st              r_out3;

    logic                          w_rdy2;
    logic                          w_rdy3;
    logic [afu_pkg::DATA_W-1:0]    w_pos;
    logic [afu_pkg::LADR_W-1:0]    w_adr;
    logic [afu_pkg::LUT_W-1:0]     w_base;
    logic [afu_pkg::LUT_W-1:0]     w_next;
    logic [afu_pkg::LUT_W-1:0]     w_diff;
    logic [afu_pkg::ACC_W-1:0]     w_acc;
    logic [afu_pkg::LUT_W:0]       w_sum;
    afu_pkg::t_sig_st              n_out3;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = w_rdy2;

    // Offset binary position: top bits pick the segment, the rest weight it.
    assign w_pos  = {~i_data.arg[afu_pkg::DATA_W-1], i_data.arg[afu_pkg::DATA_W-2:0]};
    assign w_adr  = {1'b0, w_pos[afu_pkg::DATA_W-1 -: afu_pkg::IDX_W]};
    assign w_base = afu_pkg::SIG_LUT[w_adr];
    assign w_next = afu_pkg::SIG_LUT[w_adr + afu_pkg::LADR_W'(1)];
    assign w_diff = (w_next >= w_base) ? (w_next - w_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_tag2  <= i_data.tag;
            r_base2 <= w_base;
            r_diff2 <= w_diff;
            r_rem2  <= w_pos[afu_pkg::REM_W-1:0];
        end
    end

    assign w_acc = {{(afu_pkg::ACC_W - afu_pkg::LUT_W){1'b0}}, r_diff2}
                 * {{(afu_pkg::ACC_W - afu_pkg::REM_W){1'b0}}, r_rem2}
                 + afu_pkg::ACC_W'(1 << (afu_pkg::REM_W - 1));
    assign w_sum = {1'b0, r_base2} + w_acc[afu_pkg::ACC_W-1:afu_pkg::REM_W];

    always_comb begin
        n_out3.tag = r_tag2;
        n_out3.sig = w_sum[afu_pkg::LUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_out3 <= n_out3;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_out3;

endmodule

// ===== design/afu_post.sv =====
// ----------------------------------------------------------------------------
// afu_post
// Two pipeline stages: derivative product, then rounding and result select.
// ----------------------------------------------------------------------------
module afu_post (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  afu_pkg::t_sig_st  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output afu_pkg::t_data    o_y
);

    localparam logic [afu_pkg::OP_W-1:0] ONE_U = afu_pkg::OP_W'(1 << afu_pkg::FRAC_W);

    logic                          r_v4;
    afu_pkg::t_tag                 r_tag4;
    afu_pkg::t_data                r_sig4;
    afu_pkg::t_data                r_tanh4;
    logic [afu_pkg::PROD_W-1:0]    r_prod4;
    logic                          r_v5;
    afu_pkg::t_data                r_y5;

    logic                          w_rdy4;
    logic                          w_rdy5;
    logic [afu_pkg::OP_W-1:0]      w_s;
    logic [afu_pkg::OP_W-1:0]      w_comp;
    logic signed [afu_pkg::OP_W:0] w_t;
    logic [afu_pkg::OP_W-1:0]      w_tabs;
    logic [afu_pkg::OP_W-1:0]      w_opa;
    logic [afu_pkg::OP_W-1:0]      w_opb;
    logic [afu_pkg::PROD_W-1:0]    w_rnd;
    afu_pkg::t_data                w_prod_fx;
    afu_pkg::t_data                n_y5;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign o_ready = w_rdy4;

    // tanh = 2*s - 1.0; its magnitude never exceeds 1.0.
    assign w_s    = {1'b0, i_data.sig};
    assign w_comp = ONE_U - w_s;
    assign w_t    = $signed({1'b0, i_data.sig, 1'b0}) - $signed({1'b0, ONE_U});
    assign w_tabs = w_t[afu_pkg::OP_W] ? afu_pkg::OP_W'(-w_t) : afu_pkg::OP_W'(w_t);

    always_comb begin
        if (i_data.tag.mode == afu_pkg::MODE_SIGMOID_D) begin
            w_opa = w_s;
            w_opb = w_comp;
        end else begin
            w_opa = w_tabs;
            w_opb = w_tabs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_tag4  <= i_data.tag;
            r_sig4  <= afu_pkg::t_data'({1'b0, i_data.sig});
            r_tanh4 <= afu_pkg::t_data'(w_t);
            r_prod4 <= {{afu_pkg::OP_W{1'b0}}, w_opa} * {{afu_pkg::OP_W{1'b0}}, w_opb};
        end
    end

    assign w_rnd     = r_prod4 + afu_pkg::PROD_W'(1 << (afu_pkg::FRAC_W - 1));
    assign w_prod_fx = afu_pkg::t_data'(w_rnd[afu_pkg::PROD_W-1:afu_pkg::FRAC_W]);

    always_comb begin
        unique case (r_tag4.mode)
            afu_pkg::MODE_SIGMOID:   n_y5 = r_sig4;
            afu_pkg::MODE_SIGMOID_D: n_y5 = w_prod_fx;
            afu_pkg::MODE_TANH:      n_y5 = r_tanh4;
            afu_pkg::MODE_TANH_D:    n_y5 = afu_pkg::ONE_FX - w_prod_fx;
            default:                 n_y5 = r_tag4.y_simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_rdy5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_y5 <= n_y5;
        end
    end

    assign o_valid = r_v5;
    assign o_y     = r_y5;

endmodule

// ===== design/activation_function_unit_top.sv =====
// ----------------------------------------------------------------------------
// activation_function_unit_top
// Elementwise activation unit for signed Q4.12 samples.
// ----------------------------------------------------------------------------
// The unit takes one sample per clock and gives one result per sample, in
// order; it holds that input rate for as long as the output side is not
// stalled. The five register stages are: mode decode and argument prepare,
// sigmoid breakpoint lookup, interpolation multiply, derivative multiply, and
// rounding with result select. Each stage holds a valid bit and advances when
// the stage after it is empty or moving, so a stall at the output backs up
// through the pipeline without losing or repeating a sample, and the input
// stays ready as long as the output is ready. The mode register (i_cfg_we,
// i_cfg_data) selects linear, step, sigmoid, relu or tanh, or the derivative
// of one of them; codes ten to fifteen give zero. Write it only while no
// sample is in flight. Sigmoid is interpolated over a 65 point table spanning
// the whole input range, tanh is 2*sigmoid(2x)-1 with 2x saturated, and the
// derivatives are s*(1-s) and 1-t*t, rounded half up.
// ----------------------------------------------------------------------------
module activation_function_unit_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  afu_pkg::t_mode       i_cfg_data,
    afu_x_if.sink                i_x,
    afu_y_if.source              o_y
);

    afu_pkg::t_mode    r_act_mode;
    logic              r_v1;
    afu_pkg::t_arg_st  r_s1;

    afu_pkg::t_data    w_x;
    afu_pkg::t_data    w_x2;
    afu_pkg::t_arg_st  n_s1;
    logic              w_rdy1;
    logic              w_sig_ready;
    logic              w_sig_valid;
    afu_pkg::t_sig_st  w_sig_data;
    logic              w_post_ready;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_mode <= afu_pkg::MODE_LINEAR;
        end else if (i_cfg_we) begin
            r_act_mode <= i_cfg_data;
        end
    end

    assign w_x = i_x.x_value;

    // Doubled input for tanh, saturated to the sample range.
    always_comb begin
        if (!w_x[afu_pkg::DATA_W-1] && w_x[afu_pkg::DATA_W-2]) begin
            w_x2 = afu_pkg::DATA_MAX;
        end else if (w_x[afu_pkg::DATA_W-1] && !w_x[afu_pkg::DATA_W-2]) begin
            w_x2 = afu_pkg::DATA_MIN;
        end else begin
            w_x2 = {w_x[afu_pkg::DATA_W-2:0], 1'b0};
        end
    end

    // The functions that need no table are finished here and carried along.
    always_comb begin
        n_s1.tag.mode = r_act_mode;
        n_s1.arg      = w_x;
        unique case (r_act_mode) inside
            afu_pkg::MODE_LINEAR:   n_s1.tag.y_simple = w_x;
            afu_pkg::MODE_LINEAR_D: n_s1.tag.y_simple = afu_pkg::ONE_FX;
            afu_pkg::MODE_STEP: begin
                n_s1.tag.y_simple = w_x[afu_pkg::DATA_W-1] ? '0 : afu_pkg::ONE_FX;
            end
            afu_pkg::MODE_RELU: begin
                n_s1.tag.y_simple = (w_x > 0) ? w_x : '0;
            end
            afu_pkg::MODE_RELU_D: begin
                n_s1.tag.y_simple = (w_x > 0) ? afu_pkg::ONE_FX : '0;
            end
            afu_pkg::MODE_TANH, afu_pkg::MODE_TANH_D: begin
                n_s1.tag.y_simple = '0;
                n_s1.arg          = w_x2;
            end
            default:                n_s1.tag.y_simple = '0;
        endcase
    end

    assign w_rdy1    = !r_v1 || w_sig_ready;
    assign i_x.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_x.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1 <= n_s1;
        end
    end

    afu_sigmoid u_sigmoid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .o_ready (w_sig_ready),
        .i_data  (r_s1),
        .o_valid (w_sig_valid),
        .i_ready (w_post_ready),
        .o_data  (w_sig_data)
    );

    afu_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sig_valid),
        .o_ready (w_post_ready),
        .i_data  (w_sig_data),
        .o_valid (o_y.valid),
        .i_ready (o_y.ready),
        .o_y     (o_y.y_value)
    );

endmodule

// ===== design/afu_checker.sv =====
// ----------------------------------------------------------------------------
// afu_checker
// Port level checks of the activation function unit, bound to the top level.
// ----------------------------------------------------------------------------
module afu_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_cfg_we,
    input afu_pkg::t_mode  i_cfg_data,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input afu_pkg::t_data  i_out_y
);

    afu_pkg::t_mode r_mode;

    // Mirror of the mode register as seen from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= afu_pkg::MODE_LINEAR;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input blocked while the output side is ready");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_y))
        else $error("stalled result changed or dropped");

    a_const_deriv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mode == afu_pkg::MODE_LINEAR_D |-> i_out_y == afu_pkg::ONE_FX)
        else $error("linear derivative result is not one");

endmodule

bind activation_function_unit_top afu_checker u_afu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_data  (i_cfg_data),
    .i_in_ready  (i_x.ready),
    .i_out_valid (o_y.valid),
    .i_out_ready (o_y.ready),
    .i_out_y     (o_y.y_value)
);
